// File: rtl/ccts_pkg.sv
// ----------------------------------------------------------------------------
// ccts_pkg
// Shared widths, datapath operation codes and controller/datapath structs
// for the coil combiner with temporal-SNR statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package ccts_pkg;

    // default parameter values
    localparam int MAX_TIMESTEPS_DEF = 1024;
    localparam int SAMPLE_WIDTH_DEF  = 16;

    // fixed field and state widths
    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;
    localparam int SNR_W   = 16;
    localparam int ACC_W   = 48;
    localparam int CNT_W   = 10;
    localparam int SUM_W   = 34;
    localparam int SQS_W   = 56;
    localparam int PROD_W  = 76;   // widest product of the statistics unit
    localparam int DIV_W   = 92;   // dividend width (product shifted by 16)
    localparam int MB_W    = 34;   // multiplier operand width
    localparam int ITER_W  = 7;

    // iteration counts of the shared units
    localparam logic [ITER_W-1:0] MUL_STEPS  = ITER_W'(MB_W);
    localparam logic [ITER_W-1:0] DIV_STEPS  = ITER_W'(DIV_W);
    localparam logic [ITER_W-1:0] SQRT_STEPS = ITER_W'(ACC_W / 2);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // register indexes of the configuration port
    localparam logic REG_COMBINE_MODE = 1'b0;
    localparam logic REG_STATS_PARITY = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MAC,
        OP_WFIN,
        OP_RSS_LD,
        OP_STEP,
        OP_RFIN,
        OP_SQ,
        OP_UPD,
        OP_MEAN_LD,
        OP_MEAN_FIN,
        OP_S2_FIN,
        OP_NQ_FIN,
        OP_Y_FIN,
        OP_X_FIN,
        OP_Q_FIN,
        OP_SNR_FIN,
        OP_OUT
    } ccts_op_t;

    // which iterative unit a step advances
    typedef enum logic [1:0] {
        UNIT_MUL,
        UNIT_DIV,
        UNIT_SQRT
    } ccts_unit_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic last_coil;
        logic last_time;
        logic mode;
        logic step_last;
        logic n_zero;
        logic n_lt2;
        logic stop_nq;
        logic out_free;
    } ccts_status_t;

endpackage

`default_nettype wire

// File: rtl/ccts_ctrl.sv
// ----------------------------------------------------------------------------
// ccts_ctrl
// Sequencer: walks one word through accumulate, combine, statistics update
// and, at the end of a series, the mean / temporal-SNR computation.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_ctrl import ccts_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire ccts_status_t st,
    output ccts_op_t          op
);

    typedef enum logic [23:0] {
        ST_IDLE = 24'h000001,
        ST_MAC  = 24'h000002,
        ST_WFIN = 24'h000004,
        ST_RLD  = 24'h000008,
        ST_RSQ  = 24'h000010,
        ST_RFIN = 24'h000020,
        ST_SQ   = 24'h000040,
        ST_UPD  = 24'h000080,
        ST_MLD  = 24'h000100,
        ST_MDIV = 24'h000200,
        ST_MFIN = 24'h000400,
        ST_S2   = 24'h000800,
        ST_S2F  = 24'h001000,
        ST_NQ   = 24'h002000,
        ST_NQF  = 24'h004000,
        ST_Y    = 24'h008000,
        ST_YF   = 24'h010000,
        ST_X    = 24'h020000,
        ST_XF   = 24'h040000,
        ST_QDIV = 24'h080000,
        ST_QF   = 24'h100000,
        ST_TSQ  = 24'h200000,
        ST_TF   = 24'h400000,
        ST_OUT  = 24'h800000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and operation
    always_comb begin
        state_next = state_reg;
        op         = OP_NOP;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                op = OP_MAC;
                if (!st.last_coil) begin
                    state_next = ST_IDLE;
                end else if (st.mode) begin
                    state_next = ST_WFIN;
                end else begin
                    state_next = ST_RLD;
                end
            end
            ST_WFIN: begin
                op         = OP_WFIN;
                state_next = ST_SQ;
            end
            ST_RLD: begin
                op         = OP_RSS_LD;
                state_next = ST_RSQ;
            end
            ST_RSQ: begin
                op = OP_STEP;
                if (st.step_last) state_next = ST_RFIN;
            end
            ST_RFIN: begin
                op         = OP_RFIN;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                op         = OP_SQ;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                op         = OP_UPD;
                state_next = st.last_time ? ST_MLD : ST_OUT;
            end
            ST_MLD: begin
                op         = OP_MEAN_LD;
                state_next = st.n_zero ? ST_OUT : ST_MDIV;
            end
            ST_MDIV: begin
                op = OP_STEP;
                if (st.step_last) state_next = ST_MFIN;
            end
            ST_MFIN: begin
                op         = OP_MEAN_FIN;
                state_next = st.n_lt2 ? ST_OUT : ST_S2;
            end
            ST_S2: begin
                op = OP_STEP;
                if (st.step_last) state_next = ST_S2F;
            end
            ST_S2F: begin
                op         = OP_S2_FIN;
                state_next = ST_NQ;
            end
            ST_NQ: begin
                op = OP_STEP;
                if (st.step_last) state_next = ST_NQF;
            end
            ST_NQF: begin
                op         = OP_NQ_FIN;
                state_next = st.stop_nq ? ST_OUT : ST_Y;
            end
            ST_Y: begin
                op = OP_STEP;
                if (st.step_last) state_next = ST_YF;
            end
            ST_YF: begin
                op         = OP_Y_FIN;
                state_next = ST_X;
            end
            ST_X: begin
                op = OP_STEP;
                if (st.step_last) state_next = ST_XF;
            end
            ST_XF: begin
                op         = OP_X_FIN;
                state_next = ST_QDIV;
            end
            ST_QDIV: begin
                op = OP_STEP;
                if (st.step_last) state_next = ST_QF;
            end
            ST_QF: begin
                op         = OP_Q_FIN;
                state_next = ST_TSQ;
            end
            ST_TSQ: begin
                op = OP_STEP;
                if (st.step_last) state_next = ST_TF;
            end
            ST_TF: begin
                op         = OP_SNR_FIN;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (st.out_free) begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ccts_dp.sv
// ----------------------------------------------------------------------------
// ccts_dp
// Datapath: coil accumulator, series statistics, a shared serial multiplier,
// a restoring divider, a bit-pair square root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_dp import ccts_pkg::*; #(
    parameter int MAX_TIMESTEPS = MAX_TIMESTEPS_DEF,
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic                    cfg_index,
    input  wire logic                    cfg_wdata,
    input  wire logic signed [IN_W-1:0]  s_coil_sample,
    input  wire logic signed [IN_W-1:0]  s_coil_weight,
    input  wire logic                    s_last_coil,
    input  wire logic                    s_last_time,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [OUT_W-1:0]      m_combined_value,
    output logic                         m_stats_valid,
    output logic signed [OUT_W-1:0]      m_series_mean,
    output logic [SNR_W-1:0]             m_temporal_snr,
    output logic                         m_deviation_zero,
    input  wire ccts_op_t                op,
    output ccts_status_t                 st
);

    localparam int TIW = (MAX_TIMESTEPS > 1) ? $clog2(MAX_TIMESTEPS) : 1;
    localparam logic [TIW-1:0]   T_LAST    = TIW'(MAX_TIMESTEPS - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_TIMESTEPS - 1);

    // configuration
    logic mode_reg;
    logic parity_reg;

    // captured word
    logic signed [IN_W-1:0] smp_reg;
    logic signed [IN_W-1:0] wgt_reg;
    logic                   lc_reg;
    logic                   lt_reg;

    // accumulation and series state
    logic signed [ACC_W-1:0] acc_reg;
    logic [TIW-1:0]          tidx_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQS_W-1:0]        sqs_reg;
    logic signed [OUT_W-1:0] comb_reg;
    logic [ACC_W-1:0]        csq_reg;
    logic signed [OUT_W-1:0] mean_reg;
    logic [SNR_W-1:0]        snr_reg;
    logic                    dz_reg;
    logic [PROD_W-1:0]       s2_reg;
    logic [PROD_W-1:0]       y_reg;

    // iterative units
    ccts_unit_t          unit_reg;
    logic [ITER_W-1:0]   it_reg;
    logic [PROD_W-1:0]   mp_reg;
    logic [PROD_W-1:0]   ma_reg;
    logic [MB_W-1:0]     mb_reg;
    logic [DIV_W-1:0]    dq_reg;
    logic [PROD_W-1:0]   drem_reg;
    logic [PROD_W-1:0]   dd_reg;
    logic [ACC_W-1:0]    sv_reg;
    logic [ACC_W-1:0]    sr_reg;
    logic [ACC_W-1:0]    sb_reg;

    // output register
    logic                    mv_reg;
    logic signed [OUT_W-1:0] mcomb_reg;
    logic                    mstat_reg;
    logic signed [OUT_W-1:0] mmean_reg;
    logic [SNR_W-1:0]        msnr_reg;
    logic                    mdz_reg;

    // sample sign extension from the configured width
    logic signed [SAMPLE_WIDTH-1:0] smp_lo;
    assign smp_lo = s_coil_sample[SAMPLE_WIDTH-1:0];

    // multiply-accumulate with saturation
    logic signed [2*IN_W-1:0] mac_prod;
    logic signed [ACC_W:0]    mac_sum;
    logic signed [ACC_W-1:0]  mac_sat;
    always_comb begin
        mac_prod = mode_reg ? smp_reg * wgt_reg : smp_reg * smp_reg;
        mac_sum  = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(mac_prod);
        if (mac_sum[ACC_W] != mac_sum[ACC_W-1]) begin
            mac_sat = mac_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            mac_sat = mac_sum[ACC_W-1:0];
        end
    end

    // weighted finish: divide by 4096, round half away from zero, saturate
    logic                    w_neg;
    logic [ACC_W-1:0]        w_mag;
    logic [ACC_W:0]          w_rnd;
    logic [ACC_W-12:0]       w_q;
    logic signed [OUT_W-1:0] w_comb;
    always_comb begin
        w_neg = acc_reg[ACC_W-1];
        w_mag = w_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        w_rnd = (ACC_W+1)'(w_mag) + (ACC_W+1)'(2048);
        w_q   = w_rnd[ACC_W:12];
        if (!w_neg) begin
            w_comb = (w_q > (ACC_W-11)'(OUT_MAX)) ? OUT_MAX : w_q[OUT_W-1:0];
        end else begin
            w_comb = (w_q > (ACC_W-11)'(2**(OUT_W-1))) ? OUT_MIN
                                                        : OUT_W'(-w_q[OUT_W-1:0]);
        end
    end

    // root-sum-of-squares finish: round root to nearest, saturate
    logic [OUT_W:0]          r_root;
    logic [OUT_W+1:0]        r_rnd;
    logic signed [OUT_W-1:0] r_comb;
    always_comb begin
        r_root = sr_reg[OUT_W:0];
        r_rnd  = (OUT_W+2)'(r_root) + (OUT_W+2)'(sv_reg > ACC_W'(r_root));
        r_comb = (r_rnd > (OUT_W+2)'(OUT_MAX)) ? OUT_MAX : r_rnd[OUT_W-1:0];
    end

    // series magnitude and selection
    logic [SUM_W-1:0] s_mag;
    logic             sum_pos;
    logic             stats_sel;
    assign s_mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign sum_pos   = !sum_reg[SUM_W-1] && (sum_reg != '0);
    assign stats_sel = (tidx_reg[0] == parity_reg) && (cnt_reg < CNT_LIMIT);

    // serial multiplier step
    logic [PROD_W-1:0] mul_add;
    assign mul_add = mp_reg + (mb_reg[0] ? ma_reg : '0);

    // restoring divider step
    logic [PROD_W:0] div_sh;
    logic [PROD_W:0] div_diff;
    logic            div_ge;
    assign div_sh   = {drem_reg, dq_reg[DIV_W-1]};
    assign div_diff = div_sh - {1'b0, dd_reg};
    assign div_ge   = div_sh >= {1'b0, dd_reg};

    // square root step
    logic [ACC_W-1:0] sq_try;
    logic             sq_ge;
    assign sq_try = sr_reg + sb_reg;
    assign sq_ge  = sv_reg >= sq_try;

    // divider quotient clipped to 32 bits for the final root
    logic [ACC_W-1:0] q_sat;
    assign q_sat = (dq_reg[DIV_W-1:32] != '0) ? ACC_W'(32'hFFFF_FFFF)
                                              : ACC_W'(dq_reg[31:0]);

    // mean from quotient
    logic [OUT_W-1:0] mean_q;
    assign mean_q = dq_reg[OUT_W-1:0];

    // status to controller
    always_comb begin
        st.last_coil = lc_reg;
        st.last_time = lt_reg;
        st.mode      = mode_reg;
        st.step_last = (it_reg == ITER_W'(1));
        st.n_zero    = (cnt_reg == '0);
        st.n_lt2     = (cnt_reg < CNT_W'(2));
        st.stop_nq   = (mp_reg <= s2_reg) || !sum_pos;
        st.out_free  = !mv_reg || m_ready;
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            parity_reg <= 1'b1;
            acc_reg    <= '0;
            tidx_reg   <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            sqs_reg    <= '0;
            it_reg     <= '0;
            unit_reg   <= UNIT_MUL;
            mv_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_COMBINE_MODE: mode_reg   <= cfg_wdata;
                    REG_STATS_PARITY: parity_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_ready && op != OP_OUT) mv_reg <= 1'b0;
            unique case (op)
                OP_MAC: acc_reg <= mac_sat;
                OP_WFIN, OP_RFIN: acc_reg <= '0;
                OP_RSS_LD: begin
                    unit_reg <= UNIT_SQRT;
                    it_reg   <= SQRT_STEPS;
                end
                OP_STEP: it_reg <= it_reg - ITER_W'(1);
                OP_UPD: begin
                    if (stats_sel) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        sum_reg <= sum_reg + SUM_W'(comb_reg);
                        sqs_reg <= sqs_reg + SQS_W'(csq_reg);
                    end
                    if (!lt_reg) begin
                        tidx_reg <= (tidx_reg == T_LAST) ? '0 : tidx_reg + TIW'(1);
                    end
                end
                OP_MEAN_LD, OP_X_FIN: begin
                    unit_reg <= UNIT_DIV;
                    it_reg   <= DIV_STEPS;
                end
                OP_MEAN_FIN, OP_S2_FIN, OP_NQ_FIN, OP_Y_FIN: begin
                    unit_reg <= UNIT_MUL;
                    it_reg   <= MUL_STEPS;
                end
                OP_Q_FIN: begin
                    unit_reg <= UNIT_SQRT;
                    it_reg   <= SQRT_STEPS;
                end
                OP_OUT: begin
                    mv_reg <= 1'b1;
                    if (lt_reg) begin
                        tidx_reg <= '0;
                        cnt_reg  <= '0;
                        sum_reg  <= '0;
                        sqs_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                smp_reg <= IN_W'(smp_lo);
                wgt_reg <= s_coil_weight;
                lc_reg  <= s_last_coil;
                lt_reg  <= s_last_time;
            end
            OP_WFIN: comb_reg <= w_comb;
            OP_RSS_LD: begin
                sv_reg <= acc_reg[ACC_W-1] ? '0 : ACC_W'(acc_reg);
                sr_reg <= '0;
                sb_reg <= ACC_W'(1) << (ACC_W - 2);
            end
            OP_STEP: begin
                case (unit_reg)
                    UNIT_MUL: begin
                        mp_reg <= mul_add;
                        ma_reg <= ma_reg << 1;
                        mb_reg <= mb_reg >> 1;
                    end
                    UNIT_DIV: begin
                        dq_reg   <= {dq_reg[DIV_W-2:0], div_ge};
                        drem_reg <= div_ge ? div_diff[PROD_W-1:0] : div_sh[PROD_W-1:0];
                    end
                    default: begin
                        if (sq_ge) begin
                            sv_reg <= sv_reg - sq_try;
                            sr_reg <= (sr_reg >> 1) + sb_reg;
                        end else begin
                            sr_reg <= sr_reg >> 1;
                        end
                        sb_reg <= sb_reg >> 2;
                    end
                endcase
            end
            OP_RFIN: comb_reg <= r_comb;
            OP_SQ:   csq_reg  <= ACC_W'(comb_reg * comb_reg);
            OP_UPD: begin
                mean_reg <= '0;
                snr_reg  <= '0;
                dz_reg   <= 1'b1;
            end
            OP_MEAN_LD: begin
                dq_reg   <= DIV_W'(s_mag) + DIV_W'(cnt_reg >> 1);
                drem_reg <= '0;
                dd_reg   <= PROD_W'(cnt_reg);
            end
            OP_MEAN_FIN: begin
                mean_reg <= sum_reg[SUM_W-1] ? OUT_W'(-mean_q) : mean_q;
                mp_reg   <= '0;
                ma_reg   <= PROD_W'(s_mag);
                mb_reg   <= s_mag;
            end
            OP_S2_FIN: begin
                s2_reg <= mp_reg;
                mp_reg <= '0;
                ma_reg <= PROD_W'(sqs_reg);
                mb_reg <= MB_W'(cnt_reg);
            end
            OP_NQ_FIN: begin
                if (mp_reg <= s2_reg) begin
                    snr_reg <= sum_pos ? '1 : '0;
                end else begin
                    dz_reg <= 1'b0;
                end
                ma_reg <= mp_reg - s2_reg;
                mp_reg <= '0;
                mb_reg <= MB_W'(cnt_reg);
            end
            OP_Y_FIN: begin
                y_reg  <= mp_reg;
                mp_reg <= '0;
                ma_reg <= s2_reg;
                mb_reg <= MB_W'(cnt_reg - CNT_W'(1));
            end
            OP_X_FIN: begin
                dq_reg   <= {mp_reg, 16'h0000};
                drem_reg <= '0;
                dd_reg   <= y_reg;
            end
            OP_Q_FIN: begin
                sv_reg <= q_sat;
                sr_reg <= '0;
                sb_reg <= ACC_W'(1) << (ACC_W - 2);
            end
            OP_SNR_FIN: snr_reg <= sr_reg[SNR_W-1:0];
            OP_OUT: begin
                mcomb_reg <= comb_reg;
                mstat_reg <= lt_reg;
                mmean_reg <= lt_reg ? mean_reg : '0;
                msnr_reg  <= lt_reg ? snr_reg : '0;
                mdz_reg   <= lt_reg ? dz_reg : 1'b0;
            end
            default: ;
        endcase
    end

    assign m_valid          = mv_reg;
    assign m_combined_value = mcomb_reg;
    assign m_stats_valid    = mstat_reg;
    assign m_series_mean    = mmean_reg;
    assign m_temporal_snr   = msnr_reg;
    assign m_deviation_zero = mdz_reg;

endmodule

`default_nettype wire

// File: rtl/coil_combine_tsnr.sv
// ----------------------------------------------------------------------------
// coil_combine_tsnr
// Per-voxel coil combination (root-sum-of-squares or weighted sum) with
// running temporal-SNR statistics over the time steps of one parity.
// ----------------------------------------------------------------------------
// Usage: the s_ channel takes one coil sample word per handshake, coil by
// coil, with s_last_coil closing a time step and s_last_time closing the
// series. Each word with s_last_coil set yields one m_ word carrying the
// combined value; the word that ends the series also carries the mean,
// the Q8.8 temporal SNR and the zero-deviation flag.
// Throughput: one word at a time. Ending a time step adds the combine finish
// and the statistics update, with a 24-step square root in root-sum-of-squares
// mode. Ending a series adds up to two 92-step restoring divisions, four
// 34-step serial multiplies and a second 24-step square root.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata, written while idle.
// Reset (aresetn low, synchronous) clears the accumulator and statistics and
// sets weighted mode off, odd parity. A stalled m_ready holds the result in
// the output register; the block finishes the next time step up to its result and
// then waits for the register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module coil_combine_tsnr import ccts_pkg::*; #(
    parameter int MAX_TIMESTEPS = MAX_TIMESTEPS_DEF,
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic                    cfg_index,
    input  wire logic                    cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [IN_W-1:0]  s_coil_sample,
    input  wire logic signed [IN_W-1:0]  s_coil_weight,
    input  wire logic                    s_last_coil,
    input  wire logic                    s_last_time,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [OUT_W-1:0]      m_combined_value,
    output logic                         m_stats_valid,
    output logic signed [OUT_W-1:0]      m_series_mean,
    output logic [SNR_W-1:0]             m_temporal_snr,
    output logic                         m_deviation_zero
);

    ccts_op_t     op;
    ccts_status_t st;

    // sequencer
    ccts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .op      (op)
    );

    // arithmetic and state
    ccts_dp #(
        .MAX_TIMESTEPS (MAX_TIMESTEPS),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_coil_sample    (s_coil_sample),
        .s_coil_weight    (s_coil_weight),
        .s_last_coil      (s_last_coil),
        .s_last_time      (s_last_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_combined_value (m_combined_value),
        .m_stats_valid    (m_stats_valid),
        .m_series_mean    (m_series_mean),
        .m_temporal_snr   (m_temporal_snr),
        .m_deviation_zero (m_deviation_zero),
        .op               (op),
        .st               (st)
    );

endmodule

`default_nettype wire

// File: tb/coil_combine_tsnr_tb.sv
// ----------------------------------------------------------------------------
// coil_combine_tsnr_tb
// Self-checking bench for the coil combiner. Coil sample words go in through
// a randomly idling driver, and an internal predictor works out the combined
// value and the series statistics for every word that ends a time step. A
// randomly stalling monitor compares each result word field by field. Directed
// corner cases run first, then a long wrapping series, then random series
// under every mode and parity setting.
// ----------------------------------------------------------------------------
`default_nettype none

module coil_combine_tsnr_tb;
    import ccts_pkg::*;

    typedef struct {
        logic signed [IN_W-1:0] sample;
        logic signed [IN_W-1:0] weight;
        logic                   last_coil;
        logic                   last_time;
    } coil_word_t;

    typedef struct {
        logic signed [OUT_W-1:0] combined;
        logic                    stats_valid;
        logic signed [OUT_W-1:0] mean;
        logic [SNR_W-1:0]        snr;
        logic                    dev_zero;
    } step_result_t;

    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic                    cfg_index = 1'b0;
    logic                    cfg_wdata = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [IN_W-1:0]  s_coil_sample = '0;
    logic signed [IN_W-1:0]  s_coil_weight = '0;
    logic                    s_last_coil = 1'b0;
    logic                    s_last_time = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_combined_value;
    logic                    m_stats_valid;
    logic signed [OUT_W-1:0] m_series_mean;
    logic [SNR_W-1:0]        m_temporal_snr;
    logic                    m_deviation_zero;

    coil_combine_tsnr u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_coil_sample    (s_coil_sample),
        .s_coil_weight    (s_coil_weight),
        .s_last_coil      (s_last_coil),
        .s_last_time      (s_last_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_combined_value (m_combined_value),
        .m_stats_valid    (m_stats_valid),
        .m_series_mean    (m_series_mean),
        .m_temporal_snr   (m_temporal_snr),
        .m_deviation_zero (m_deviation_zero)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic         weighted_mode = 1'b0;
    logic         odd_parity = 1'b1;
    longint       coil_acc = 0;
    int           step_index = 0;
    int           stat_count = 0;
    longint       stat_sum = 0;
    logic [63:0]  stat_sq_sum = '0;

    coil_word_t   pending_words[$];
    step_result_t expected_results[$];
    logic         no_gaps = 1'b0;
    int           words_sent = 0;
    int           results_seen = 0;
    int           series_ended = 0;
    int           errors = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // mean, Q8.8 temporal snr and zero-deviation flag of the series so far
    task automatic series_figures(output logic [OUT_W-1:0] mean,
                                  output logic [SNR_W-1:0] snr, output logic dz);
        longint unsigned n, mag, q, t, c;
        logic [127:0] nq, s2, d, rhs, cw;
        n = stat_count;
        mag = stat_sum < 0 ? -stat_sum : stat_sum;
        mean = '0;
        snr = '0;
        dz = 1'b1;
        t = 0;
        if (n == 0) return;
        q = (mag + n / 2) / n;
        mean = OUT_W'(stat_sum < 0 ? -longint'(q) : longint'(q));
        if (n < 2) return;
        nq = 128'(n) * 128'(stat_sq_sum);
        s2 = 128'(mag) * 128'(mag);
        if (nq <= s2) begin
            snr = stat_sum > 0 ? 16'hFFFF : 16'h0;
            return;
        end
        d = nq - s2;
        dz = 1'b0;
        if (stat_sum <= 0) return;
        rhs = s2 * 128'((n - 1) << 16);
        for (longint unsigned b = 32768; b != 0; b >>= 1) begin
            c = t | b;
            cw = 128'(c);
            if (d * cw * cw * 128'(n) <= rhs) t = c;
        end
        snr = SNR_W'(t);
    endtask

    // accumulate one accepted word, queue the step result when it closes a step
    task automatic predict_word(input coil_word_t w);
        longint       comb;
        longint unsigned a, r, mag;
        step_result_t res;
        if (weighted_mode) coil_acc += longint'(w.sample) * longint'(w.weight);
        else               coil_acc += longint'(w.sample) * longint'(w.sample);
        if (coil_acc > ACC_HI) coil_acc = ACC_HI;
        if (coil_acc < ACC_LO) coil_acc = ACC_LO;
        if (!w.last_coil) return;
        if (!weighted_mode) begin
            a = coil_acc > 0 ? coil_acc : 0;
            r = int_sqrt(a);
            if (a - r * r > r) r++;
            comb = r > 8388607 ? 8388607 : longint'(r);
        end else begin
            mag = coil_acc < 0 ? -coil_acc : coil_acc;
            comb = longint'((mag + 2048) >> 12);
            if (coil_acc < 0) comb = -comb;
            if (comb > 8388607) comb = 8388607;
            if (comb < -8388608) comb = -8388608;
        end
        coil_acc = 0;
        if (step_index[0] == odd_parity && stat_count < 1023) begin
            stat_count++;
            stat_sum += comb;
            stat_sq_sum += 64'(comb * comb);
        end
        res.combined = OUT_W'(comb);
        res.stats_valid = w.last_time;
        res.mean = '0;
        res.snr = '0;
        res.dev_zero = 1'b0;
        if (w.last_time) begin
            series_figures(res.mean, res.snr, res.dev_zero);
            step_index = 0;
            stat_count = 0;
            stat_sum = 0;
            stat_sq_sum = '0;
        end else begin
            step_index = step_index >= 1023 ? 0 : step_index + 1;
        end
        expected_results.push_back(res);
    endtask

    // driver: one word per handshake, random gap after each
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            coil_word_t cur;
            cur.sample = s_coil_sample;
            cur.weight = s_coil_weight;
            cur.last_coil = s_last_coil;
            cur.last_time = s_last_time;
            predict_word(cur);
            words_sent++;
            tx_gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (tx_gap == 0 && pending_words.size() > 0) begin
                cur = pending_words.pop_front();
                s_coil_sample <= cur.sample;
                s_coil_weight <= cur.weight;
                s_last_coil <= cur.last_coil;
                s_last_time <= cur.last_time;
            end else begin
                s_valid <= 1'b0;
            end
        end else if (!s_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_words.size() > 0) begin
                coil_word_t nxt;
                nxt = pending_words.pop_front();
                s_valid <= 1'b1;
                s_coil_sample <= nxt.sample;
                s_coil_weight <= nxt.weight;
                s_last_coil <= nxt.last_coil;
                s_last_time <= nxt.last_time;
            end
        end
    end

    // monitor: compare results, random stalls and one long hold-off
    int rx_wait = 0;
    int rx_hold = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                step_result_t e;
                results_seen++;
                if (m_stats_valid) series_ended++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word, combined %0d", $time,
                             m_combined_value);
                end else begin
                    e = expected_results.pop_front();
                    if (m_combined_value !== e.combined) begin
                        errors++;
                        $display("%0t: combined_value exp %0d got %0d", $time,
                                 e.combined, m_combined_value);
                    end
                    if (m_stats_valid !== e.stats_valid) begin
                        errors++;
                        $display("%0t: stats_valid exp %0b got %0b", $time,
                                 e.stats_valid, m_stats_valid);
                    end
                    if (m_series_mean !== e.mean) begin
                        errors++;
                        $display("%0t: series_mean exp %0d got %0d", $time,
                                 e.mean, m_series_mean);
                    end
                    if (m_temporal_snr !== e.snr) begin
                        errors++;
                        $display("%0t: temporal_snr exp %0d got %0d", $time,
                                 e.snr, m_temporal_snr);
                    end
                    if (m_deviation_zero !== e.dev_zero) begin
                        errors++;
                        $display("%0t: deviation_zero exp %0b got %0b", $time,
                                 e.dev_zero, m_deviation_zero);
                    end
                end
                rx_wait = no_gaps ? 0 : $urandom_range(0, 4);
                if (results_seen == 40) rx_hold = 400;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(input int smp, input int wgt, input logic lc,
                             input logic lt);
        coil_word_t w;
        w.sample = IN_W'(smp);
        w.weight = IN_W'(wgt);
        w.last_coil = lc;
        w.last_time = lt;
        pending_words.push_back(w);
    endtask

    // everything sent and answered, then room for a step still in flight
    task automatic wait_idle();
        while (pending_words.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (500) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_COMBINE_MODE) weighted_mode = val;
        else                         odd_parity = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one random series: half full-range data, the rest constant, small or extremes
    task automatic random_series();
        int steps, coils, flavor, fixed_smp, fixed_wgt, smp, wgt;
        steps = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        flavor = $urandom_range(0, 5);
        fixed_smp = $urandom_range(0, 65535);
        fixed_wgt = $urandom_range(0, 65535);
        for (int t = 0; t < steps; t++) begin
            coils = $urandom_range(1, 4);
            for (int c = 0; c < coils; c++) begin
                case (flavor)
                    0:       begin smp = fixed_smp; wgt = fixed_wgt; end
                    1:       begin smp = $urandom_range(0, 200) - 100;
                                   wgt = $urandom_range(0, 8192); end
                    2:       begin smp = $urandom_range(0, 1) ? 32767 : -32768;
                                   wgt = $urandom_range(0, 1) ? 32767 : -32768; end
                    default: begin smp = $urandom_range(0, 65535);
                                   wgt = $urandom_range(0, 65535); end
                endcase
                if (c == coils - 1) push_word(smp, wgt, 1'b1, t == steps - 1);
                else push_word(smp, wgt, 1'b0, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // root-sum-of-squares corners: empty series, single step, constant
        write_cfg(REG_COMBINE_MODE, 1'b0);
        write_cfg(REG_STATS_PARITY, 1'b1);
        push_word(-32768, 0, 1'b1, 1'b1);
        push_word(32767, 0, 1'b1, 1'b0);
        push_word(-32768, 0, 1'b1, 1'b1);
        for (int t = 0; t < 4; t++) push_word(100, 0, 1'b1, t == 3);
        push_word(3, 0, 1'b0, 1'b0);
        push_word(4, 0, 1'b1, 1'b0);
        push_word(1, 0, 1'b0, 1'b1);
        push_word(1, 0, 1'b1, 1'b1);
        wait_idle();

        // weighted corners: rounding ties, extremes, 24-bit saturation
        write_cfg(REG_COMBINE_MODE, 1'b1);
        write_cfg(REG_STATS_PARITY, 1'b0);
        push_word(1, 2048, 1'b1, 1'b0);
        push_word(-1, 2048, 1'b1, 1'b0);
        push_word(-32768, -32768, 1'b1, 1'b0);
        push_word(-32768, 32767, 1'b1, 1'b0);
        for (int c = 0; c < 40; c++) push_word(32767, 32767, c == 39, 1'b0);
        push_word(-500, 4096, 1'b1, 1'b1);
        wait_idle();

        // mode switch inside a step leaves a negative accumulator for rss
        push_word(100, -32768, 1'b0, 1'b0);
        wait_idle();
        write_cfg(REG_COMBINE_MODE, 1'b0);
        push_word(1, 0, 1'b1, 1'b1);
        // sender pauses mid-series until all results are back
        push_word(20, 0, 1'b1, 1'b0);
        push_word(30, 0, 1'b1, 1'b0);
        wait_idle();
        push_word(70, 0, 1'b1, 1'b1);
        wait_idle();

        // series longer than the step counter: index wraps
        write_cfg(REG_COMBINE_MODE, 1'b1);
        for (int t = 0; t < 1030; t++)
            push_word($urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1,
                      t == 1029);
        wait_idle();

        // random series under every setting
        for (int ph = 0; ph < 8; ph++) begin
            write_cfg(REG_COMBINE_MODE, ph[0]);
            write_cfg(REG_STATS_PARITY, ph[1]);
            no_gaps = (ph == 5);
            for (int s = 0; s < 3; s++) random_series();
            wait_idle();
        end
        no_gaps = 1'b0;

        $display("sent %0d coil words, checked %0d step results over %0d series",
                 words_sent, results_seen, series_ended);
        $display("covered both modes and parities, index wrap, 24-bit limits, stalls");
        if (errors == 0) $display("coil_combine_tsnr_tb OK");
        else             $display("coil_combine_tsnr_tb NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #60000000;
        $display("timeout");
        $display("coil_combine_tsnr_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/ccts_pkg.sv
rtl/ccts_ctrl.sv
rtl/ccts_dp.sv
rtl/coil_combine_tsnr.sv
tb/coil_combine_tsnr_tb.sv
